/* sv/ljpg_pkg.sv */
// Shared types, register codes and constants of the Lennard-Jones grid potential block.
`default_nettype none
package ljpg_pkg;

	localparam int AXIS_POINTS_DEF = 64;

	localparam int IDX_W  = 6;
	localparam int SP_W   = 20;
	localparam int SQ_W   = 48;
	localparam int POT_W  = 32;
	localparam int ADDR_W = 6;
	localparam int DATA_W = 64;

	typedef enum logic [2:0] {
		REG_SPACING_X = 3'd0,
		REG_SPACING_Y = 3'd1,
		REG_SPACING_Z = 3'd2,
		REG_SIGMA_SQ  = 3'd3,
		REG_RCUT_SQ   = 3'd4,
		REG_COEF_A    = 3'd5,
		REG_COEF_B    = 3'd6
	} reg_idx_t;

	localparam logic [SP_W-1:0] SPACING_RST  = 20'd65536;
	localparam logic [SQ_W-1:0] SIGMA_SQ_RST = 48'd4294967296;
	localparam logic [SQ_W-1:0] RCUT_SQ_RST  = 48'd26843545600;
	localparam logic [SQ_W-1:0] COEF_RST     = 48'd262144;

	localparam logic [POT_W-1:0] POT_MAX = 32'h7FFF_FFFF;
	localparam logic [POT_W-1:0] POT_MIN = 32'h8000_0000;

	typedef struct packed {
		logic [SP_W-1:0] spacing_x;
		logic [SP_W-1:0] spacing_y;
		logic [SP_W-1:0] spacing_z;
		logic [SQ_W-1:0] sigma_sq;
		logic [SQ_W-1:0] rcut_sq;
		logic [SQ_W-1:0] coef_a;
		logic [SQ_W-1:0] coef_b;
	} cfg_t;

	typedef struct packed {
		logic [IDX_W-1:0] idx_x;
		logic [IDX_W-1:0] idx_y;
		logic [IDX_W-1:0] idx_z;
	} in_word_t;

	typedef struct packed {
		logic signed [POT_W-1:0] potential;
		logic                    saturated;
	} out_word_t;

endpackage
`default_nettype wire

/* sv/ljpg_pipe.sv */
// Pipelined datapath: squared distance, exact powers, and a 32-stage restoring divider.
`default_nettype none
module ljpg_pipe #(
	parameter int AXIS_POINTS = ljpg_pkg::AXIS_POINTS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  ljpg_pkg::cfg_t      cfg,
	input  logic                in_valid,
	output logic                in_stall,
	input  ljpg_pkg::in_word_t  in_word,
	output logic                out_valid,
	input  logic                out_stall,
	output ljpg_pkg::out_word_t out_word
);
	import ljpg_pkg::*;

	localparam int NST   = 45;
	localparam int DIV_N = 32;
	localparam int DIV0  = 11;
	localparam int LW    = 24;
	localparam int D_W   = 26;
	localparam int SQD_W = 52;
	localparam int RR_W  = 54;
	localparam int R2_W  = 96;
	localparam int R3_W  = 144;
	localparam int R6_W  = 288;
	localparam int CB_W  = 192;
	localparam int ROW_W = 168;
	localparam int RCB_W = 72;
	localparam int RW    = 290;
	localparam logic [10:0] AXIS_LIM = 11'(AXIS_POINTS);

	logic [NST-1:0] pv_q;
	logic [NST-1:0] adv;

	// A stage moves on when it is empty or the stage after it moves on.
	always_comb begin
		adv[NST-1] = !pv_q[NST-1] || !out_stall;
		for (int k = NST-2; k >= 0; k--) begin
			adv[k] = !pv_q[k] || adv[k+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pv_q <= '0;
		end else begin
			if (adv[0]) begin
				pv_q[0] <= in_valid;
			end
			for (int k = 1; k < NST; k++) begin
				if (adv[k]) begin
					pv_q[k] <= pv_q[k-1];
				end
			end
		end
	end

	assign in_stall  = !adv[0];
	assign out_valid = pv_q[NST-1];

	// Stage 1: axis offsets.
	logic [D_W-1:0] dx_s1, dy_s1, dz_s1;
	logic           z_s1;
	logic           oob;

	assign oob = ({5'd0, in_word.idx_x} >= AXIS_LIM) || ({5'd0, in_word.idx_y} >= AXIS_LIM)
		|| ({5'd0, in_word.idx_z} >= AXIS_LIM);

	always_ff @(posedge clk) begin
		if (adv[0]) begin
			dx_s1 <= {20'd0, in_word.idx_x} * {6'd0, cfg.spacing_x};
			dy_s1 <= {20'd0, in_word.idx_y} * {6'd0, cfg.spacing_y};
			dz_s1 <= {20'd0, in_word.idx_z} * {6'd0, cfg.spacing_z};
			z_s1  <= oob;
		end
	end

	// Stage 2: squares.
	logic [SQD_W-1:0] sx_s2, sy_s2, sz_s2;
	logic             z_s2;

	always_ff @(posedge clk) begin
		if (adv[1]) begin
			sx_s2 <= {26'd0, dx_s1} * {26'd0, dx_s1};
			sy_s2 <= {26'd0, dy_s1} * {26'd0, dy_s1};
			sz_s2 <= {26'd0, dz_s1} * {26'd0, dz_s1};
			z_s2  <= z_s1;
		end
	end

	// Stage 3: squared distance and range check.
	logic [RR_W-1:0] rr_sum;
	logic [SQ_W-1:0] rr_s3;
	logic            z_s3;

	assign rr_sum = {2'd0, sx_s2} + {2'd0, sy_s2} + {2'd0, sz_s2};

	always_ff @(posedge clk) begin
		if (adv[2]) begin
			rr_s3 <= rr_sum[SQ_W-1:0];
			z_s3  <= z_s2 || (rr_sum == '0) || (rr_sum < {6'd0, cfg.sigma_sq})
				|| (rr_sum > {6'd0, cfg.rcut_sq});
		end
	end

	// Stages 4 and 5: rr squared from 24-bit partial products.
	logic [2*LW-1:0] pp2_s4 [2][2];
	logic [SQ_W-1:0] r_s4, r_s5;
	logic            z_s4, z_s5;
	logic [R2_W-1:0] r2_sum, r2_s5;

	always_ff @(posedge clk) begin
		if (adv[3]) begin
			for (int i = 0; i < 2; i++) begin
				for (int j = 0; j < 2; j++) begin
					pp2_s4[i][j] <= {24'd0, rr_s3[LW*i +: LW]} * {24'd0, rr_s3[LW*j +: LW]};
				end
			end
			r_s4 <= rr_s3;
			z_s4 <= z_s3;
		end
	end

	always_comb begin
		r2_sum = '0;
		for (int i = 0; i < 2; i++) begin
			for (int j = 0; j < 2; j++) begin
				r2_sum = r2_sum + (R2_W'(pp2_s4[i][j]) << (LW*(i+j)));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv[4]) begin
			r2_s5 <= r2_sum;
			r_s5  <= r_s4;
			z_s5  <= z_s4;
		end
	end

	// Stages 6 and 7: rr cubed.
	logic [2*LW-1:0] pp3_s6 [4][2];
	logic            z_s6, z_s7;
	logic [R3_W-1:0] r3_sum, r3_s7;

	always_ff @(posedge clk) begin
		if (adv[5]) begin
			for (int i = 0; i < 4; i++) begin
				for (int j = 0; j < 2; j++) begin
					pp3_s6[i][j] <= {24'd0, r2_s5[LW*i +: LW]} * {24'd0, r_s5[LW*j +: LW]};
				end
			end
			z_s6 <= z_s5;
		end
	end

	always_comb begin
		r3_sum = '0;
		for (int i = 0; i < 4; i++) begin
			for (int j = 0; j < 2; j++) begin
				r3_sum = r3_sum + (R3_W'(pp3_s6[i][j]) << (LW*(i+j)));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv[6]) begin
			r3_s7 <= r3_sum;
			z_s7  <= z_s6;
		end
	end

	// Stages 8 to 10: rr to the sixth and coef_b times rr cubed.
	logic [2*LW-1:0]  pp6_s8 [6][6];
	logic [2*LW-1:0]  ppb_s8 [2][6];
	logic             z_s8, z_s9, z_s10;
	logic [ROW_W-1:0] row6_s9 [6];
	logic [RCB_W-1:0] rowb_s9 [6];
	logic [R6_W-1:0]  r6_sum, r6_s10;
	logic [CB_W-1:0]  cb_sum, cb_s10;

	always_ff @(posedge clk) begin
		if (adv[7]) begin
			for (int i = 0; i < 6; i++) begin
				for (int j = 0; j < 6; j++) begin
					pp6_s8[i][j] <= {24'd0, r3_s7[LW*i +: LW]} * {24'd0, r3_s7[LW*j +: LW]};
				end
			end
			for (int i = 0; i < 2; i++) begin
				for (int j = 0; j < 6; j++) begin
					ppb_s8[i][j] <= {24'd0, cfg.coef_b[LW*i +: LW]} * {24'd0, r3_s7[LW*j +: LW]};
				end
			end
			z_s8 <= z_s7;
		end
	end

	always_ff @(posedge clk) begin
		logic [ROW_W-1:0] acc6;
		logic [RCB_W-1:0] accb;
		if (adv[8]) begin
			for (int j = 0; j < 6; j++) begin
				acc6 = '0;
				for (int i = 0; i < 6; i++) begin
					acc6 = acc6 + (ROW_W'(pp6_s8[i][j]) << (LW*i));
				end
				row6_s9[j] <= acc6;
				accb = RCB_W'(ppb_s8[0][j]) + (RCB_W'(ppb_s8[1][j]) << LW);
				rowb_s9[j] <= accb;
			end
			z_s9 <= z_s8;
		end
	end

	always_comb begin
		r6_sum = '0;
		cb_sum = '0;
		for (int j = 0; j < 6; j++) begin
			r6_sum = r6_sum + (R6_W'(row6_s9[j]) << (LW*j));
			cb_sum = cb_sum + (CB_W'(rowb_s9[j]) << (LW*j));
		end
	end

	always_ff @(posedge clk) begin
		if (adv[9]) begin
			r6_s10 <= r6_sum;
			cb_s10 <= cb_sum;
			z_s10  <= z_s9;
		end
	end

	// Stage 11: signed numerator magnitude.
	logic [CB_W-1:0] a_sh;
	logic [CB_W-1:0] m_s11;
	logic [R6_W-1:0] d_s11;
	logic            neg_s11, z_s11;

	assign a_sh = {cfg.coef_a, 144'd0} >> 48;

	always_ff @(posedge clk) begin
		if (adv[10]) begin
			if (a_sh >= cb_s10) begin
				m_s11   <= a_sh - cb_s10;
				neg_s11 <= 1'b0;
			end else begin
				m_s11   <= cb_s10 - a_sh;
				neg_s11 <= 1'b1;
			end
			d_s11 <= r6_s10;
			z_s11 <= z_s10;
		end
	end

	// Stages 12 to 44: overflow check, then one quotient bit per stage.
	logic [RW-1:0]    div_rem_s [DIV_N+1];
	logic [R6_W-1:0]  div_d_s   [DIV_N+1];
	logic [POT_W-1:0] div_q_s   [DIV_N+1];
	logic             div_neg_s [DIV_N+1];
	logic             div_z_s   [DIV_N+1];
	logic             div_sat_s [DIV_N+1];
	logic [RW-1:0]    hi0;
	logic [RW-1:0]    rem_nx    [DIV_N+1];
	logic             bit_nx    [DIV_N+1];

	assign hi0 = {34'd0, m_s11, 64'd0};

	always_comb begin
		logic [RW-1:0] r2;
		rem_nx[0] = '0;
		bit_nx[0] = 1'b0;
		for (int k = 1; k <= DIV_N; k++) begin
			r2 = {div_rem_s[k-1][RW-2:0], 1'b0};
			bit_nx[k] = r2 >= {2'd0, div_d_s[k-1]};
			rem_nx[k] = bit_nx[k] ? (r2 - {2'd0, div_d_s[k-1]}) : r2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv[DIV0]) begin
			div_sat_s[0] <= hi0 >= {2'd0, d_s11};
			div_rem_s[0] <= hi0;
			div_d_s[0]   <= d_s11;
			div_q_s[0]   <= '0;
			div_neg_s[0] <= neg_s11;
			div_z_s[0]   <= z_s11;
		end
		for (int k = 1; k <= DIV_N; k++) begin
			if (adv[DIV0+k]) begin
				div_rem_s[k] <= rem_nx[k];
				div_d_s[k]   <= div_d_s[k-1];
				div_q_s[k]   <= {div_q_s[k-1][POT_W-2:0], bit_nx[k]};
				div_neg_s[k] <= div_neg_s[k-1];
				div_z_s[k]   <= div_z_s[k-1];
				div_sat_s[k] <= div_sat_s[k-1];
			end
		end
	end

	// Stage 45: sign, clipping and the zero cases.
	out_word_t res;
	out_word_t out_s45;
	logic [POT_W-1:0] quo;

	assign quo = div_q_s[DIV_N];

	always_comb begin
		res.potential = '0;
		res.saturated = 1'b0;
		if (div_z_s[DIV_N]) begin
			res.potential = '0;
		end else if (div_sat_s[DIV_N]) begin
			res.potential = div_neg_s[DIV_N] ? POT_MIN : POT_MAX;
			res.saturated = 1'b1;
		end else if (!div_neg_s[DIV_N]) begin
			if (quo > POT_MAX) begin
				res.potential = POT_MAX;
				res.saturated = 1'b1;
			end else begin
				res.potential = quo;
			end
		end else begin
			if (quo > POT_MIN) begin
				res.potential = POT_MIN;
				res.saturated = 1'b1;
			end else begin
				res.potential = 32'd0 - quo;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv[NST-1]) begin
			out_s45 <= res;
		end
	end

	assign out_word = out_s45;

	// The input side only stalls when every stage is full and the output is held.
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> ((&pv_q) && out_stall))
		else $error("input stalled while the pipeline has a free stage");

	// The partial remainder stays below the divisor once the overflow check has passed.
	a_rem_first: assert property (@(posedge clk) disable iff (!arst_n)
		(pv_q[DIV0] && !div_z_s[0] && !div_sat_s[0])
		|-> (div_rem_s[0] < {2'd0, div_d_s[0]}))
		else $error("initial remainder not below divisor");

	a_rem_last: assert property (@(posedge clk) disable iff (!arst_n)
		(pv_q[DIV0+DIV_N] && !div_z_s[DIV_N] && !div_sat_s[DIV_N])
		|-> (div_rem_s[DIV_N] < {2'd0, div_d_s[DIV_N]}))
		else $error("final remainder not below divisor");

	a_sat_value: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_word.saturated)
		|-> (out_word.potential == POT_MAX || out_word.potential == POT_MIN))
		else $error("saturated word carries an unclipped value");

endmodule
`default_nettype wire

/* sv/lj_pair_potential_grid_top.sv */
// Throughput: one word per cycle while the output is not held; a held output lets the empty stages keep filling.
// The rate is set by the 45-stage pipeline: products, sums, and one quotient bit per stage.
// Reset clears all pipeline valid bits and loads every configuration register with its default value.
// No clearing pass is needed; the block takes words on the first cycle after reset.
`default_nettype none
module lj_pair_potential_grid_top #(
	parameter int AXIS_POINTS = ljpg_pkg::AXIS_POINTS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [ljpg_pkg::ADDR_W-1:0] paddr,
	input  logic [ljpg_pkg::DATA_W-1:0] pwdata,
	output logic [ljpg_pkg::DATA_W-1:0] prdata,
	output logic                        pready,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  ljpg_pkg::in_word_t          in_word,
	output logic                        out_valid,
	input  logic                        out_stall,
	output ljpg_pkg::out_word_t         out_word
);
	import ljpg_pkg::*;

	cfg_t     cfg_q;
	logic     wr_en;
	reg_idx_t reg_sel;

	// Registers sit on 8-byte boundaries since the widest one is 48 bits.
	assign reg_sel = reg_idx_t'(paddr[5:3]);
	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite && pready;

	// Configuration registers; a write to an unused slot is dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.spacing_x <= SPACING_RST;
			cfg_q.spacing_y <= SPACING_RST;
			cfg_q.spacing_z <= SPACING_RST;
			cfg_q.sigma_sq  <= SIGMA_SQ_RST;
			cfg_q.rcut_sq   <= RCUT_SQ_RST;
			cfg_q.coef_a    <= COEF_RST;
			cfg_q.coef_b    <= COEF_RST;
		end else if (wr_en) begin
			case (reg_sel)
				REG_SPACING_X: cfg_q.spacing_x <= pwdata[SP_W-1:0];
				REG_SPACING_Y: cfg_q.spacing_y <= pwdata[SP_W-1:0];
				REG_SPACING_Z: cfg_q.spacing_z <= pwdata[SP_W-1:0];
				REG_SIGMA_SQ:  cfg_q.sigma_sq  <= pwdata[SQ_W-1:0];
				REG_RCUT_SQ:   cfg_q.rcut_sq   <= pwdata[SQ_W-1:0];
				REG_COEF_A:    cfg_q.coef_a    <= pwdata[SQ_W-1:0];
				REG_COEF_B:    cfg_q.coef_b    <= pwdata[SQ_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Read back is zero-extended to the bus width.
	always_comb begin
		case (reg_sel)
			REG_SPACING_X: prdata = {44'd0, cfg_q.spacing_x};
			REG_SPACING_Y: prdata = {44'd0, cfg_q.spacing_y};
			REG_SPACING_Z: prdata = {44'd0, cfg_q.spacing_z};
			REG_SIGMA_SQ:  prdata = {16'd0, cfg_q.sigma_sq};
			REG_RCUT_SQ:   prdata = {16'd0, cfg_q.rcut_sq};
			REG_COEF_A:    prdata = {16'd0, cfg_q.coef_a};
			REG_COEF_B:    prdata = {16'd0, cfg_q.coef_b};
			default:       prdata = '0;
		endcase
	end

	// The datapath computes coef_a/rr^6 - coef_b/rr^3 exactly, truncated toward zero.
	ljpg_pipe #(
		.AXIS_POINTS(AXIS_POINTS)
	) u_pipe (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_word  (in_word),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_word (out_word)
	);

endmodule
`default_nettype wire
